// File: src/thick_line_rasterizer_defines.svh
// ---------------------------------------------------------------------------
// Thick line rasterizer assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef THICK_LINE_RASTERIZER_DEFINES_SVH
`define THICK_LINE_RASTERIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TLR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/tlr_pkg.sv
// ---------------------------------------------------------------------------
// Thick line rasterizer package
// Shared constants, state and select codes, and controller/datapath structs.
// ---------------------------------------------------------------------------
package tlr_pkg;

	// Parameter defaults
	localparam int DEF_MAX_THICKNESS = 8;
	localparam int DEF_COORD_BITS    = 12;

	// Fixed field widths
	localparam int CFG_BITS     = 11;
	localparam int CFG_IDX_BITS = 1;
	localparam int THICK_BITS   = 4;
	localparam int COLOR_BITS   = 16;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;
	localparam logic [CFG_BITS-1:0]     SCREEN_WIDTH_RST  = 11'd368;
	localparam logic [CFG_BITS-1:0]     SCREEN_HEIGHT_RST = 11'd448;

	// Item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_ROWS
	} tlr_state_t;

	// Result source
	typedef enum logic [1:0] {
		SEL_ACK,
		SEL_NOLINE,
		SEL_ROW
	} tlr_sel_t;

	typedef struct packed {
		logic     load_line;
		logic     out_load;
		tlr_sel_t sel;
		logic     row_inc;
		logic     row_clr;
		logic     step_end;
	} tlr_cmd_t;

	typedef struct packed {
		logic load_ok;
		logic active;
		logic last_row;
	} tlr_sts_t;

endpackage

// File: src/thick_line_rasterizer.sv
// ---------------------------------------------------------------------------
// Thick line rasterizer
// Bresenham line walker that plots each point as a clipped vertical run.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): a start item (kind 0) loads endpoints,
//   color and thickness and yields one acknowledgment result. Each step item
//   (kind 1) yields one result per row of the held thickness, row y first,
//   then y+1 and onward; the last one carries last=1.
//   Output channel (out_valid/out_stall): one result register. The first
//   result of an item is loaded in the cycle the item is accepted and shows
//   in the next cycle; further rows follow one per cycle while not stalled.
//   A step item holds the input channel until its last row is loaded into
//   the single result register; a start item or a step with no line does not.
//   A stalled receiver holds the result register; the row sequence and
//   the input channel wait until it frees up.
//   Reset clears the line (no active line) and sets the screen to 368x448.
//   Screen size is written through wr_en/wr_index/wr_data; the user must
//   write it only while idle, as the block itself does not enforce it.
// ---------------------------------------------------------------------------
module thick_line_rasterizer #(
	parameter int MAX_THICKNESS = tlr_pkg::DEF_MAX_THICKNESS,
	parameter int COORD_BITS    = tlr_pkg::DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [tlr_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [tlr_pkg::CFG_BITS-1:0]        wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	input  logic [tlr_pkg::COLOR_BITS-1:0]      line_color,
	input  logic [tlr_pkg::THICK_BITS-1:0]      line_thickness,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        pixel_x,
	output logic signed [COORD_BITS:0]          pixel_y,
	output logic [tlr_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                                write_enable,
	output logic                                last,
	output logic                                line_done,
	output logic                                busy_res
);
	import tlr_pkg::*;

	tlr_cmd_t cmd;
	tlr_sts_t sts;

	// Sequencer
	tlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Line state and result register
	tlr_dp #(
		.MAX_THICKNESS (MAX_THICKNESS),
		.COORD_BITS    (COORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.start_x        (start_x),
		.start_y        (start_y),
		.end_x          (end_x),
		.end_y          (end_y),
		.line_color     (line_color),
		.line_thickness (line_thickness),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_color    (pixel_color),
		.write_enable   (write_enable),
		.last           (last),
		.line_done      (line_done),
		.busy_res       (busy_res)
	);

endmodule

// File: src/tlr_ctrl.sv
// ---------------------------------------------------------------------------
// Thick line rasterizer controller
// Sequences input acceptance and the per-row result emission of a step item.
// ---------------------------------------------------------------------------
`include "thick_line_rasterizer_defines.svh"

module tlr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  tlr_pkg::tlr_sts_t sts,
	output tlr_pkg::tlr_cmd_t cmd
);
	import tlr_pkg::*;

	tlr_state_t state_q;
	tlr_state_t state_d;
	logic       accept;

	assign accept = in_valid && !in_stall;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_STEP && sts.active && !sts.last_row) begin
					state_d = ST_ROWS;
				end
			end
			ST_ROWS: begin
				if (sts.load_ok && sts.last_row) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands and input stall
	always_comb begin
		in_stall      = 1'b1;
		cmd.load_line = 1'b0;
		cmd.out_load  = 1'b0;
		cmd.sel       = SEL_ACK;
		cmd.row_inc   = 1'b0;
		cmd.row_clr   = 1'b0;
		cmd.step_end  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = !sts.load_ok;
				if (in_valid && sts.load_ok) begin
					cmd.out_load = 1'b1;
					if (kind == KIND_START) begin
						cmd.sel       = SEL_ACK;
						cmd.load_line = 1'b1;
					end else if (!sts.active) begin
						cmd.sel = SEL_NOLINE;
					end else begin
						// first row goes out with the accept
						cmd.sel = SEL_ROW;
						if (sts.last_row) begin
							cmd.step_end = 1'b1;
						end else begin
							cmd.row_inc = 1'b1;
						end
					end
				end
			end
			ST_ROWS: begin
				if (sts.load_ok) begin
					cmd.out_load = 1'b1;
					cmd.sel      = SEL_ROW;
					if (sts.last_row) begin
						cmd.step_end = 1'b1;
						cmd.row_clr  = 1'b1;
					end else begin
						cmd.row_inc = 1'b1;
					end
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	`TLR_ASSERT_NOW(a_rows_need_line, state_q == ST_ROWS, sts.active, "row burst without line")
	`TLR_ASSERT_NOW(a_rows_hold_input, state_q == ST_ROWS, in_stall, "input taken in row burst")
	`TLR_ASSERT_NEXT(a_start_to_idle, accept && kind == KIND_START, state_q == ST_IDLE, "start not idle")

endmodule

// File: src/tlr_dp.sv
// ---------------------------------------------------------------------------
// Thick line rasterizer datapath
// Line state, Bresenham step, clipping, configuration and result register.
// ---------------------------------------------------------------------------
`include "thick_line_rasterizer_defines.svh"

module tlr_dp #(
	parameter int MAX_THICKNESS = tlr_pkg::DEF_MAX_THICKNESS,
	parameter int COORD_BITS    = tlr_pkg::DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlr_pkg::tlr_cmd_t                   cmd,
	output tlr_pkg::tlr_sts_t                   sts,
	input  logic                                wr_en,
	input  logic [tlr_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [tlr_pkg::CFG_BITS-1:0]        wr_data,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	input  logic [tlr_pkg::COLOR_BITS-1:0]      line_color,
	input  logic [tlr_pkg::THICK_BITS-1:0]      line_thickness,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        pixel_x,
	output logic signed [COORD_BITS:0]          pixel_y,
	output logic [tlr_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                                write_enable,
	output logic                                last,
	output logic                                line_done,
	output logic                                busy_res
);
	import tlr_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int TW  = $clog2(MAX_THICKNESS + 1);
	localparam int RW  = (MAX_THICKNESS > 1) ? $clog2(MAX_THICKNESS) : 1;
	localparam int TCW = (TW > THICK_BITS) ? TW : THICK_BITS;
	localparam int CW  = (CB + 1 > CFG_BITS) ? CB + 1 : CFG_BITS;

	// Configuration
	logic [CFG_BITS-1:0] screen_width_q;
	logic [CFG_BITS-1:0] screen_height_q;

	// Line state
	logic signed [CB-1:0] cur_x_q, cur_y_q, target_x_q, target_y_q;
	logic signed [CB:0]   delta_x_q, neg_delta_y_q;
	logic signed [CB+1:0] error_term_q;
	logic                 step_x_neg_q, step_y_neg_q;
	logic [COLOR_BITS-1:0] held_color_q;
	logic [TW-1:0]        held_thick_q;
	logic                 active_q;
	logic [RW-1:0]        row_q;

	// Result register
	logic                  out_valid_q;
	logic signed [CB-1:0]  pixel_x_q;
	logic signed [CB:0]    pixel_y_q;
	logic [COLOR_BITS-1:0] pixel_color_q;
	logic                  write_enable_q, last_q, line_done_q, busy_res_q;

	// Start-item arithmetic
	logic signed [CB:0]   sx0, sy0, sx1, sy1, dx_w, ndy_w;
	logic signed [CB+1:0] err_init_w;
	logic [TCW-1:0]       thick_ext;
	logic [TCW-1:0]       thick_clamp;

	// Step arithmetic
	logic signed [CB+2:0] e2_w;
	logic                 move_x, move_y;
	logic signed [CB+1:0] err_next_w;
	logic                 done_w;
	logic signed [CB:0]   row_y_w;
	logic                 x_on, y_on, row_last_w;
	logic                 load_ok;

	// Handshake status
	assign load_ok      = !out_valid_q || !out_stall;
	assign row_last_w   = (TW'(row_q) == held_thick_q - TW'(1));
	assign sts.load_ok  = load_ok;
	assign sts.active   = active_q;
	assign sts.last_row = row_last_w;

	// Endpoint deltas and thickness clamp
	always_comb begin
		sx0        = {start_x[CB-1], start_x};
		sy0        = {start_y[CB-1], start_y};
		sx1        = {end_x[CB-1], end_x};
		sy1        = {end_y[CB-1], end_y};
		dx_w       = (sx1 > sx0) ? sx1 - sx0 : sx0 - sx1;
		ndy_w      = (sy1 > sy0) ? sy0 - sy1 : sy1 - sy0;
		err_init_w = {dx_w[CB], dx_w} + {ndy_w[CB], ndy_w};
		thick_ext  = TCW'(line_thickness);
		if (thick_ext == '0) begin
			thick_clamp = TCW'(1);
		end else if (thick_ext > TCW'(MAX_THICKNESS)) begin
			thick_clamp = TCW'(MAX_THICKNESS);
		end else begin
			thick_clamp = thick_ext;
		end
	end

	// Bresenham error step
	always_comb begin
		e2_w       = {error_term_q, 1'b0};
		move_x     = (e2_w >= (CB+3)'(neg_delta_y_q));
		move_y     = (e2_w <= (CB+3)'(delta_x_q));
		err_next_w = error_term_q
			+ (move_x ? (CB+2)'(neg_delta_y_q) : '0)
			+ (move_y ? (CB+2)'(delta_x_q) : '0);
		done_w     = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
	end

	// Current row pixel and clipping
	always_comb begin
		row_y_w = {cur_y_q[CB-1], cur_y_q} + (CB+1)'(row_q);
		x_on    = !cur_x_q[CB-1] &&
			(CW'($unsigned(cur_x_q)) < CW'(screen_width_q));
		y_on    = !row_y_w[CB] &&
			(CW'($unsigned(row_y_w)) < CW'(screen_height_q));
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= wr_data;
				REG_SCREEN_HEIGHT: screen_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Line state: load on start, advance or finish at the last row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			target_x_q    <= '0;
			target_y_q    <= '0;
			delta_x_q     <= '0;
			neg_delta_y_q <= '0;
			error_term_q  <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			held_color_q  <= '0;
			held_thick_q  <= TW'(1);
			active_q      <= 1'b0;
		end else if (cmd.load_line) begin
			cur_x_q       <= start_x;
			cur_y_q       <= start_y;
			target_x_q    <= end_x;
			target_y_q    <= end_y;
			delta_x_q     <= dx_w;
			neg_delta_y_q <= ndy_w;
			error_term_q  <= err_init_w;
			step_x_neg_q  <= !(sx0 < sx1);
			step_y_neg_q  <= !(sy0 < sy1);
			held_color_q  <= line_color;
			held_thick_q  <= TW'(thick_clamp);
			active_q      <= 1'b1;
		end else if (cmd.step_end) begin
			if (done_w) begin
				active_q <= 1'b0;
			end else begin
				error_term_q <= err_next_w;
				if (move_x) begin
					cur_x_q <= step_x_neg_q ? cur_x_q - CB'(1) : cur_x_q + CB'(1);
				end
				if (move_y) begin
					cur_y_q <= step_y_neg_q ? cur_y_q - CB'(1) : cur_y_q + CB'(1);
				end
			end
		end
	end

	// Row counter within one step item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.row_clr) begin
			row_q <= '0;
		end else if (cmd.row_inc) begin
			row_q <= row_q + RW'(1);
		end
	end

	// Result valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.sel)
				SEL_ROW: begin
					pixel_x_q      <= cur_x_q;
					pixel_y_q      <= row_y_w;
					pixel_color_q  <= held_color_q;
					write_enable_q <= x_on && y_on;
					last_q         <= row_last_w;
					line_done_q    <= done_w;
					busy_res_q     <= !done_w;
				end
				SEL_ACK: begin
					pixel_x_q      <= '0;
					pixel_y_q      <= '0;
					pixel_color_q  <= '0;
					write_enable_q <= 1'b0;
					last_q         <= 1'b1;
					line_done_q    <= 1'b0;
					busy_res_q     <= 1'b1;
				end
				default: begin
					pixel_x_q      <= '0;
					pixel_y_q      <= '0;
					pixel_color_q  <= '0;
					write_enable_q <= 1'b0;
					last_q         <= 1'b1;
					line_done_q    <= 1'b0;
					busy_res_q     <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign pixel_color  = pixel_color_q;
	assign write_enable = write_enable_q;
	assign last         = last_q;
	assign line_done    = line_done_q;
	assign busy_res     = busy_res_q;

	`TLR_ASSERT_NOW(a_row_in_range, 1'b1, TW'(row_q) < held_thick_q, "row index past thickness")
	`TLR_ASSERT_NOW(a_load_when_free, cmd.out_load, load_ok, "result overwritten while held")
	`TLR_ASSERT_NEXT(a_end_clears_line, cmd.step_end && done_w, !active_q, "line kept after end")

endmodule
